### rtl/irm_pkg.sv
// Shared types, codes and the bus script table of the I2C register master.
`timescale 1ns / 1ps

package irm_pkg;

  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd100;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_CHECK = 2'd3
  } irm_func_t;

  typedef enum logic [3:0] {
    IT_END   = 4'd0,
    IT_START = 4'd1,
    IT_DEVW  = 4'd2,
    IT_DEVR  = 4'd3,
    IT_REG   = 4'd4,
    IT_DATA  = 4'd5,
    IT_SLOT  = 4'd6,
    IT_STOP  = 4'd7,
    IT_RECV  = 4'd8,
    IT_WAIT  = 4'd9
  } irm_item_t;

  typedef struct packed {
    irm_func_t  func;
    logic [6:0] target_addr;
    logic [7:0] reg_addr;
    logic [7:0] wr_data;
    logic       sda_in;
  } irm_in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_data;
    logic       ack_seen;
  } irm_out_t;

  // Bus item played at a given script position for a given command.
  function automatic irm_item_t irm_script(input irm_func_t op, input logic [3:0] pos);
    irm_item_t it;
    it = IT_END;
    case (op)
      FUNC_WRITE: begin
        case (pos)
          4'd1: it = IT_START;
          4'd2: it = IT_DEVW;
          4'd3: it = IT_SLOT;
          4'd4: it = IT_REG;
          4'd5: it = IT_SLOT;
          4'd6: it = IT_DATA;
          4'd7: it = IT_SLOT;
          4'd8: it = IT_STOP;
          default: it = IT_END;
        endcase
      end
      FUNC_READ: begin
        case (pos)
          4'd1:  it = IT_START;
          4'd2:  it = IT_DEVW;
          4'd3:  it = IT_SLOT;
          4'd4:  it = IT_REG;
          4'd5:  it = IT_SLOT;
          4'd6:  it = IT_STOP;
          4'd7:  it = IT_START;
          4'd8:  it = IT_DEVR;
          4'd9:  it = IT_SLOT;
          4'd10: it = IT_RECV;
          4'd11: it = IT_SLOT;
          4'd12: it = IT_STOP;
          default: it = IT_END;
        endcase
      end
      FUNC_CHECK: begin
        case (pos)
          4'd1: it = IT_START;
          4'd2: it = IT_DEVW;
          4'd3: it = IT_WAIT;
          4'd4: it = IT_STOP;
          default: it = IT_END;
        endcase
      end
      default: it = IT_END;
    endcase
    return it;
  endfunction

endpackage

### rtl/irm_chan_if.sv
// Valid/ready channel interface carrying one payload word.
`timescale 1ns / 1ps

interface irm_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/i2c_register_master.sv
// Top level of the I2C register master: tick sequencer with registered results.
//
//   channel   direction  word            handshake
//   in_if     sink       irm_in_t        valid/ready, one bit-phase tick
//   out_if    source     irm_out_t       valid/ready, one result per tick
//   cfg_if    sink       16-bit timeout  valid/ready, always ready
//
// Each accepted tick updates the registered bus state and registers its result
// for out_if; a tick can be accepted every cycle while the skid is empty.
// The result register plus a one-word skid register keep input accepted
// while one result waits; input stalls only when both are full.
// Synchronous active-low reset releases both lines and returns to idle.
`timescale 1ns / 1ps

module i2c_register_master
  import irm_pkg::*;
(
  input logic clk,
  input logic rst_n,
  irm_chan_if.sink   in_if,
  irm_chan_if.source out_if,
  irm_chan_if.sink   cfg_if
);

  logic [15:0] ack_timeout_r;
  logic [3:0]  pos_r, pos_nxt;
  logic [1:0]  sub_r, sub_nxt;
  logic [3:0]  bit_index_r, bit_index_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  read_byte_r, read_byte_nxt;
  logic [15:0] wait_count_r, wait_count_nxt;
  logic [6:0]  dev_r, dev_nxt;
  logic [7:0]  reg_r, reg_nxt;
  logic [7:0]  data_r, data_nxt;
  irm_func_t   op_r, op_nxt;
  logic        ack_r, ack_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;

  irm_out_t    out_r, skid_r, res;
  logic        out_valid_r, skid_valid_r;
  logic        accept, take, done;

  irm_item_t   it, nit;
  logic        next_item, bitdone, hold;
  logic [3:0]  bi, np;

  assign accept = in_if.valid && in_if.ready;
  assign take   = out_valid_r && out_if.ready;
  assign in_if.ready  = !skid_valid_r;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  always_comb begin
    pos_nxt        = pos_r;
    sub_nxt        = sub_r;
    bit_index_nxt  = bit_index_r;
    shift_nxt      = shift_r;
    read_byte_nxt  = read_byte_r;
    wait_count_nxt = wait_count_r;
    dev_nxt        = dev_r;
    reg_nxt        = reg_r;
    data_nxt       = data_r;
    op_nxt         = op_r;
    ack_nxt        = ack_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    done           = 1'b0;
    next_item      = 1'b0;
    bitdone        = 1'b0;
    hold           = 1'b0;
    it             = irm_script(op_r, pos_r);
    bi             = bit_index_r + 4'd1;
    np             = pos_r + 4'd1;
    nit            = irm_script(op_r, np);

    if (pos_r == 4'd0 && sub_r == 2'd0) begin
      if (in_if.data.func != FUNC_TICK) begin
        op_nxt   = in_if.data.func;
        dev_nxt  = in_if.data.target_addr;
        reg_nxt  = in_if.data.reg_addr;
        data_nxt = in_if.data.wr_data;
        pos_nxt  = 4'd1;
        sub_nxt  = 2'd0;
      end
    end else if (sub_r == 2'd3) begin
      pos_nxt = 4'd0;
      sub_nxt = 2'd0;
    end else begin
      case (it)
        IT_START: begin
          scl_nxt = (sub_r == 2'd0);
          sda_nxt = 1'b0;
          next_item = (sub_r != 2'd0);
        end
        IT_DEVW, IT_DEVR, IT_REG, IT_DATA: begin
          scl_nxt = (sub_r == 2'd1);
          sda_nxt = shift_r[7];
          if (sub_r == 2'd2) begin
            shift_nxt = {shift_r[6:0], 1'b0};
            bitdone   = 1'b1;
          end
        end
        IT_SLOT: begin
          scl_nxt = (sub_r == 2'd1);
          sda_nxt = 1'b1;
          next_item = (sub_r == 2'd2);
        end
        IT_STOP: begin
          scl_nxt = (sub_r != 2'd0);
          sda_nxt = (sub_r == 2'd2);
          next_item = (sub_r == 2'd2);
        end
        IT_RECV: begin
          scl_nxt = (sub_r == 2'd1);
          sda_nxt = 1'b1;
          if (sub_r == 2'd1) begin
            shift_nxt = {shift_r[6:0], in_if.data.sda_in};
          end
          bitdone = (sub_r == 2'd2);
        end
        IT_WAIT: begin
          scl_nxt = (sub_r == 2'd1);
          sda_nxt = 1'b1;
          if (sub_r == 2'd1) begin
            if (!in_if.data.sda_in) begin
              ack_nxt = 1'b1;
            end else if (wait_count_r == 16'd0) begin
              ack_nxt = 1'b0;
            end else begin
              wait_count_nxt = wait_count_r - 16'd1;
              hold = 1'b1;
            end
          end
          next_item = (sub_r == 2'd2);
        end
        default: begin
          pos_nxt = 4'd0;
          sub_nxt = 2'd0;
          hold    = 1'b1;
        end
      endcase

      if (!hold) begin
        if (bitdone) begin
          bit_index_nxt = bi;
          if (bi[3]) begin
            if (it == IT_RECV) begin
              read_byte_nxt = shift_r;
            end
            next_item = 1'b1;
          end else begin
            sub_nxt = 2'd0;
          end
        end
        if (next_item) begin
          pos_nxt       = np;
          sub_nxt       = 2'd0;
          bit_index_nxt = 4'd0;
          case (nit)
            IT_END: begin
              pos_nxt = 4'd0;
              done    = 1'b1;
            end
            IT_DEVW: shift_nxt = {dev_r, 1'b0};
            IT_DEVR: shift_nxt = {dev_r, 1'b1};
            IT_REG:  shift_nxt = reg_r;
            IT_DATA: shift_nxt = data_r;
            IT_RECV: shift_nxt = 8'd0;
            IT_WAIT: wait_count_nxt = ack_timeout_r;
            default: ;
          endcase
        end else if (!bitdone) begin
          sub_nxt = sub_r + 2'd1;
        end
      end
    end

    res.scl_out  = scl_nxt;
    res.sda_out  = sda_nxt;
    res.busy_res = (pos_nxt != 4'd0) || (sub_nxt != 2'd0);
    res.done_res = done;
    res.rd_data  = read_byte_nxt;
    res.ack_seen = ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      ack_timeout_r <= cfg_if.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= 4'd0;
      sub_r        <= 2'd0;
      bit_index_r  <= 4'd0;
      shift_r      <= 8'd0;
      read_byte_r  <= 8'd0;
      wait_count_r <= 16'd0;
      dev_r        <= 7'd0;
      reg_r        <= 8'd0;
      data_r       <= 8'd0;
      op_r         <= FUNC_TICK;
      ack_r        <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
    end else if (accept) begin
      pos_r        <= pos_nxt;
      sub_r        <= sub_nxt;
      bit_index_r  <= bit_index_nxt;
      shift_r      <= shift_nxt;
      read_byte_r  <= read_byte_nxt;
      wait_count_r <= wait_count_nxt;
      dev_r        <= dev_nxt;
      reg_r        <= reg_nxt;
      data_r       <= data_nxt;
      op_r         <= op_nxt;
      ack_r        <= ack_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
    end
  end

  // A new word goes to the result register when it is free or being taken,
  // otherwise to the skid register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (accept) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r  <= skid_valid_r;
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_valid_r || take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end else if (take && skid_valid_r) begin
      out_r <= skid_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a word while the result register is empty");

  a_idle_sub_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == 4'd0) |-> (sub_r == 2'd0))
    else $error("sub-tick nonzero while idle");

  a_cmd_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && pos_r == 4'd0 && in_if.data.func != FUNC_TICK)
      |=> (pos_r == 4'd1 && sub_r == 2'd0))
    else $error("accepted command did not start the script");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && done) |=> (pos_r == 4'd0 && scl_r && sda_r))
    else $error("transaction end left the bus busy or the lines driven");
`endif

endmodule

### test/irm_bus_checker.sv
// Scoreboard that predicts every result word of the I2C register master and compares it.
`timescale 1ns / 1ps

module irm_bus_checker
  import irm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  irm_chan_if         in_if,
  irm_chan_if         out_if,
  irm_chan_if         cfg_if,
  output int unsigned fail_count,
  output int unsigned pending,
  output logic        bus_idle,
  output int unsigned words_checked,
  output int unsigned writes_done,
  output int unsigned reads_done,
  output int unsigned checks_done,
  output int unsigned checks_acked
);

  logic [15:0] ack_timeout;
  logic [5:0]  phase;
  logic [3:0]  bit_index;
  logic [7:0]  shift_byte;
  logic [7:0]  read_byte;
  logic [15:0] wait_count;
  irm_func_t   op_func;
  logic [6:0]  op_dev;
  logic [7:0]  op_reg;
  logic [7:0]  op_data;
  logic        ack_flag;
  logic        scl_level;
  logic        sda_level;
  irm_out_t    result_words_due [$];

  // Bus item at each script position, position 0 in the rightmost slot.
  function automatic irm_item_t seq_item(irm_func_t op, logic [3:0] pos);
    logic [15:0][3:0] row;
    case (op)
      FUNC_WRITE: row = {{7{IT_END}}, IT_STOP, IT_SLOT, IT_DATA, IT_SLOT, IT_REG, IT_SLOT,
                         IT_DEVW, IT_START, IT_END};
      FUNC_READ:  row = {{3{IT_END}}, IT_STOP, IT_SLOT, IT_RECV, IT_SLOT, IT_DEVR, IT_START,
                         IT_STOP, IT_SLOT, IT_REG, IT_SLOT, IT_DEVW, IT_START, IT_END};
      FUNC_CHECK: row = {{11{IT_END}}, IT_STOP, IT_WAIT, IT_DEVW, IT_START, IT_END};
      default:    row = {16{IT_END}};
    endcase
    return irm_item_t'(row[pos]);
  endfunction

  function automatic void drive_lines(logic scl, logic sda);
    scl_level = scl;
    sda_level = sda;
  endfunction

  function automatic logic load_item(logic [3:0] pos);
    irm_item_t it;
    it = seq_item(op_func, pos);
    phase = {pos, 2'd0};
    bit_index = 4'd0;
    case (it)
      IT_END: begin
        phase = 6'd0;
        return 1'b1;
      end
      IT_DEVW: shift_byte = {op_dev, 1'b0};
      IT_DEVR: shift_byte = {op_dev, 1'b1};
      IT_REG:  shift_byte = op_reg;
      IT_DATA: shift_byte = op_data;
      IT_RECV: shift_byte = 8'd0;
      IT_WAIT: wait_count = ack_timeout;
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic logic bus_tick(logic sda_in);
    logic [3:0] pos;
    logic [1:0] sub;
    irm_item_t  it;
    logic       advance;
    logic       bit_done;
    pos = phase[5:2];
    sub = phase[1:0];
    it = seq_item(op_func, pos);
    advance = 1'b0;
    bit_done = 1'b0;
    if (sub == 2'd3) begin
      phase = 6'd0;
      return 1'b0;
    end
    case (it)
      IT_START: begin
        if (sub == 2'd0) begin
          drive_lines(1'b1, 1'b0);
        end else begin
          drive_lines(1'b0, 1'b0);
          advance = 1'b1;
        end
      end
      IT_DEVW, IT_DEVR, IT_REG, IT_DATA: begin
        drive_lines(sub == 2'd1, shift_byte[7]);
        if (sub == 2'd2) begin
          shift_byte = shift_byte << 1;
          bit_done = 1'b1;
        end
      end
      IT_SLOT: begin
        drive_lines(sub == 2'd1, 1'b1);
        advance = (sub == 2'd2);
      end
      IT_STOP: begin
        drive_lines(sub != 2'd0, sub == 2'd2);
        advance = (sub == 2'd2);
      end
      IT_RECV: begin
        drive_lines(sub == 2'd1, 1'b1);
        if (sub == 2'd1) shift_byte = {shift_byte[6:0], sda_in};
        if (sub == 2'd2) bit_done = 1'b1;
      end
      IT_WAIT: begin
        drive_lines(sub == 2'd1, 1'b1);
        if (sub == 2'd1) begin
          if (!sda_in) begin
            ack_flag = 1'b1;
          end else if (wait_count == 16'd0) begin
            ack_flag = 1'b0;
          end else begin
            wait_count = wait_count - 16'd1;
            return 1'b0;
          end
        end
        advance = (sub == 2'd2);
      end
      default: begin
        phase = 6'd0;
        return 1'b0;
      end
    endcase
    if (bit_done) begin
      bit_index = bit_index + 4'd1;
      if (bit_index >= 4'd8) begin
        if (it == IT_RECV) read_byte = shift_byte;
        advance = 1'b1;
      end else begin
        phase = {pos, 2'd0};
        return 1'b0;
      end
    end
    if (advance) return load_item(pos + 4'd1);
    phase = {pos, sub + 2'd1};
    return 1'b0;
  endfunction

  function automatic irm_out_t bus_step(irm_in_t w);
    irm_out_t r;
    logic     done;
    done = 1'b0;
    if (phase == 6'd0) begin
      if (w.func != FUNC_TICK) begin
        op_func = w.func;
        op_dev = w.target_addr;
        op_reg = w.reg_addr;
        op_data = w.wr_data;
        phase = {4'd1, 2'd0};
      end
    end else begin
      done = bus_tick(w.sda_in);
    end
    r.scl_out = scl_level;
    r.sda_out = sda_level;
    r.busy_res = (phase != 6'd0);
    r.done_res = done;
    r.rd_data = read_byte;
    r.ack_seen = ack_flag;
    if (done) begin
      case (op_func)
        FUNC_WRITE: writes_done++;
        FUNC_READ:  reads_done++;
        FUNC_CHECK: begin
          checks_done++;
          if (ack_flag) checks_acked++;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    irm_out_t want;
    irm_out_t got;
    if (!rst_n) begin
      ack_timeout = ACK_TIMEOUT_RST;
      phase = 6'd0;
      bit_index = 4'd0;
      shift_byte = 8'd0;
      read_byte = 8'd0;
      wait_count = 16'd0;
      op_func = FUNC_TICK;
      op_dev = 7'd0;
      op_reg = 8'd0;
      op_data = 8'd0;
      ack_flag = 1'b0;
      scl_level = 1'b1;
      sda_level = 1'b1;
      result_words_due.delete();
      fail_count = 0;
      words_checked = 0;
      writes_done = 0;
      reads_done = 0;
      checks_done = 0;
      checks_acked = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        words_checked++;
        if (result_words_due.size() == 0) begin
          if (fail_count < 10) $display("%0t: result word with nothing expected", $time);
          fail_count++;
        end else begin
          want = result_words_due.pop_front();
          if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
              got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
              got.rd_data !== want.rd_data || got.ack_seen !== want.ack_seen) begin
            if (fail_count < 10) begin
              $display("%0t: word %0d expected scl=%b sda=%b busy=%b done=%b rd=%02h ack=%b",
                       $time, words_checked, want.scl_out, want.sda_out, want.busy_res,
                       want.done_res, want.rd_data, want.ack_seen);
              $display("%0t: word %0d actual   scl=%b sda=%b busy=%b done=%b rd=%02h ack=%b",
                       $time, words_checked, got.scl_out, got.sda_out, got.busy_res,
                       got.done_res, got.rd_data, got.ack_seen);
            end
            fail_count++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) ack_timeout = cfg_if.data;
      if (in_if.valid && in_if.ready) result_words_due.push_back(bus_step(in_if.data));
    end
    pending = result_words_due.size();
    bus_idle = (phase == 6'd0);
  end

endmodule

### test/tb_top.sv
// Testbench top for the I2C register master: stimulus, flow control and the verdict.
`timescale 1ns / 1ps

module tb_top;
  import irm_pkg::*;

  typedef enum int {
    SDA_HIGH,
    SDA_LOW,
    SDA_COIN,
    SDA_RARE_LOW
  } sda_mode_t;

  localparam int TOTAL_TICKS = 950;

  logic        clk;
  logic        rst_n;
  logic        tx_quiet;
  logic        rx_quiet;
  logic        bus_idle;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_checked;
  int unsigned writes_done;
  int unsigned reads_done;
  int unsigned checks_done;
  int unsigned checks_acked;
  int unsigned ticks_sent;
  int unsigned results_taken;
  int unsigned timeout_writes;

  irm_chan_if #(.T(irm_in_t))     in_if ();
  irm_chan_if #(.T(irm_out_t))    out_if ();
  irm_chan_if #(.T(logic [15:0])) cfg_if ();

  i2c_register_master dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  irm_bus_checker line_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_if        (in_if),
    .out_if       (out_if),
    .cfg_if       (cfg_if),
    .fail_count   (fail_count),
    .pending      (pending),
    .bus_idle     (bus_idle),
    .words_checked(words_checked),
    .writes_done  (writes_done),
    .reads_done   (reads_done),
    .checks_done  (checks_done),
    .checks_acked (checks_acked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic pick_sda(sda_mode_t mode);
    case (mode)
      SDA_HIGH: return 1'b1;
      SDA_LOW:  return 1'b0;
      SDA_COIN: return 1'($urandom);
      default:  return ($urandom_range(0, 15) != 0);
    endcase
  endfunction

  function automatic irm_in_t noise_word();
    irm_in_t w;
    w.func = irm_func_t'($urandom_range(0, 3));
    w.target_addr = 7'($urandom);
    w.reg_addr = 8'($urandom);
    w.wr_data = 8'($urandom);
    w.sda_in = 1'($urandom);
    return w;
  endfunction

  // Entered and left at a falling edge.
  task automatic send_word(irm_in_t w);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= w;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_timeout(logic [15:0] value);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    timeout_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic idle_ticks(int count);
    irm_in_t w;
    repeat (count) begin
      w = noise_word();
      w.func = FUNC_TICK;
      send_word(w);
    end
  endtask

  // Issues one command and keeps ticking until the transaction has finished.
  task automatic run_command(irm_func_t op, logic [6:0] dev, logic [7:0] regaddr,
                             logic [7:0] data, sda_mode_t mode);
    irm_in_t w;
    tx_quiet = ($urandom_range(0, 4) == 0);
    w.func = op;
    w.target_addr = dev;
    w.reg_addr = regaddr;
    w.wr_data = data;
    w.sda_in = pick_sda(mode);
    send_word(w);
    while (!bus_idle) begin
      w = noise_word();
      w.sda_in = pick_sda(mode);
      if ($urandom_range(0, 149) == 0) drain();
      send_word(w);
    end
  endtask

  initial begin : result_sink
    int gap;
    out_if.ready = 1'b0;
    rx_quiet = 1'b0;
    results_taken = 0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (results_taken % 64 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      gap = rx_quiet ? 0 : $urandom_range(0, 18);
      // Long hold-offs let the block fill up and stall its input.
      if (results_taken == 120 || results_taken == 900) gap = 90;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
      results_taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [15:0] limit;
    irm_func_t   op;
    sda_mode_t   mode;
    rst_n = 1'b0;
    tx_quiet = 1'b0;
    ticks_sent = 0;
    timeout_writes = 0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_ticks(3);
    run_command(FUNC_WRITE, 7'h7f, 8'hff, 8'hff, SDA_COIN);
    run_command(FUNC_WRITE, 7'h00, 8'h00, 8'h00, SDA_COIN);
    idle_ticks(2);
    run_command(FUNC_READ, 7'h55, 8'haa, 8'h5a, SDA_HIGH);
    run_command(FUNC_READ, 7'h2a, 8'h55, 8'ha5, SDA_LOW);
    run_command(FUNC_CHECK, 7'h7f, 8'h00, 8'h00, SDA_HIGH);
    run_command(FUNC_CHECK, 7'h00, 8'hff, 8'hff, SDA_LOW);
    set_timeout(16'd0);
    run_command(FUNC_CHECK, 7'h33, 8'h12, 8'h34, SDA_HIGH);
    run_command(FUNC_CHECK, 7'h4c, 8'h56, 8'h78, SDA_LOW);
    set_timeout(16'hffff);
    run_command(FUNC_CHECK, 7'h19, 8'h9a, 8'hbc, SDA_COIN);
    run_command(FUNC_CHECK, 7'h66, 8'hde, 8'hf0, SDA_LOW);
    set_timeout(16'd1);
    run_command(FUNC_CHECK, 7'h01, 8'h01, 8'h01, SDA_HIGH);
    idle_ticks(2);

    while (ticks_sent < TOTAL_TICKS) begin
      case ($urandom_range(0, 5))
        0:       limit = 16'd0;
        1:       limit = 16'd1;
        2:       limit = 16'hffff;
        3:       limit = 16'($urandom);
        default: limit = 16'($urandom_range(2, 300));
      endcase
      set_timeout(limit);
      repeat ($urandom_range(2, 5)) begin
        if (ticks_sent >= TOTAL_TICKS) break;
        op = irm_func_t'($urandom_range(1, 3));
        mode = sda_mode_t'($urandom_range(0, 3));
        // A check that never sees an acknowledge must end in a bounded wait.
        if (op == FUNC_CHECK && limit > 16'd300 && mode == SDA_HIGH) mode = SDA_COIN;
        run_command(op, 7'($urandom), 8'($urandom), 8'($urandom), mode);
        idle_ticks($urandom_range(0, 3));
      end
    end

    drain();
    repeat (10) @(negedge clk);
    $display("Checked %0d result words from %0d ticks.", words_checked, ticks_sent);
    $display("Finished %0d writes, %0d reads, %0d checks (%0d acked), timeout written %0d times.",
             writes_done, reads_done, checks_done, checks_acked, timeout_writes);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/irm_pkg.sv
rtl/irm_chan_if.sv
rtl/i2c_register_master.sv
test/irm_bus_checker.sv
test/tb_top.sv
